// ----- sv/psgw_pkg.sv -----
`timescale 1ns / 1ps

package psgw_pkg;

  localparam int NUM_TONES = 3;
  localparam int CLK_W     = 24;
  localparam int PER_W     = 10;
  localparam int AMP_W     = 4;
  localparam int QUO_W     = 19;
  localparam int LVL_W     = 6;
  localparam int BYTE_W    = 8;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 24'd3579545;
  localparam logic [1:0]       CH_NOISE       = 2'd3;

  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [PER_W-1:0] period;
  } pick_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- sv/psgw_regs.sv -----
`timescale 1ns / 1ps

module psgw_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [psgw_pkg::BYTE_W-1:0]    wr_byte,
  output psgw_pkg::pick_t                pick
);

  logic [1:0]                    ch_r;
  logic                          is_vol_r;
  logic [psgw_pkg::PER_W-1:0]    period_r [psgw_pkg::NUM_TONES];
  logic [psgw_pkg::AMP_W-1:0]    amp_r    [psgw_pkg::NUM_TONES];

  logic [1:0] ch_nxt;
  logic       is_vol_nxt;

  // a latch byte retargets before its own payload is applied
  assign ch_nxt     = wr_byte[7] ? wr_byte[6:5] : ch_r;
  assign is_vol_nxt = wr_byte[7] ? wr_byte[4]   : is_vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= 2'd0;
      is_vol_r <= 1'b0;
      for (int i = 0; i < psgw_pkg::NUM_TONES; i++) begin
        period_r[i] <= '0;
        amp_r[i]    <= '0;
      end
    end else if (wr_en) begin
      ch_r     <= ch_nxt;
      is_vol_r <= is_vol_nxt;
      if (ch_nxt != psgw_pkg::CH_NOISE) begin
        for (int i = 0; i < psgw_pkg::NUM_TONES; i++) begin
          if (ch_nxt == i[1:0]) begin
            if (is_vol_nxt) begin
              amp_r[i] <= ~wr_byte[3:0];  // 15 - attenuation
            end else if (wr_byte[7]) begin
              period_r[i] <= {period_r[i][9:4], wr_byte[3:0]};
            end else begin
              period_r[i] <= {wr_byte[5:0], period_r[i][3:0]};
            end
          end
        end
      end
    end
  end

  // loudest channel, strict compare so the lowest index wins ties
  always_comb begin
    pick = '0;
    for (int i = 0; i < psgw_pkg::NUM_TONES; i++) begin
      if (amp_r[i] > pick.amp) begin
        pick.amp    = amp_r[i];
        pick.period = period_r[i];
      end
    end
  end

endmodule

// ----- sv/psgw_div.sv -----
`timescale 1ns / 1ps

module psgw_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [psgw_pkg::QUO_W-1:0]   dividend,
  input  logic [psgw_pkg::PER_W-1:0]   divisor,
  output logic                         busy,
  output logic                         done,
  output logic [psgw_pkg::QUO_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(psgw_pkg::QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(psgw_pkg::QUO_W - 1);

  logic [psgw_pkg::QUO_W-1:0] quo_r;
  logic [psgw_pkg::PER_W-1:0] rem_r;
  logic [psgw_pkg::PER_W-1:0] dvs_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [psgw_pkg::PER_W:0]   trial;
  logic [psgw_pkg::PER_W:0]   diff;
  logic                       ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign trial = {rem_r, quo_r[psgw_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[psgw_pkg::QUO_W-2:0], ge};
      rem_r <= ge ? diff[psgw_pkg::PER_W-1:0] : trial[psgw_pkg::PER_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/psg_register_write_tone_select_core.sv -----
`timescale 1ns / 1ps

// Register port of a three-tone sound generator, reporting the loudest tone.
// Input channel: in_valid / in_stall with in_write_byte, one chip port byte
// per word. Result channel: out_valid / out_stall with out_tone_freq_hz and
// out_tone_level, exactly one result word per input word, in order.
// cfg_wr_en / cfg_wr_data write the chip clock in hertz; write it only
// while the block is idle.
// Each byte updates the channel registers at acceptance, then a shared
// restoring divider computes (clock / 32) / period one quotient bit per
// cycle, 19 bits in all. The states pick, divide and done follow in turn,
// and no new byte is taken until the done state hands the result on.
// in_stall is high from acceptance until the result is handed to the
// output register. The output register lets the next byte in while a
// result waits; if out_stall holds that result, the next one waits in the
// block and in_stall stays high.
// Reset (rst_n low, synchronous) clears the channel registers, drops
// out_valid and sets the clock to 3579545 Hz.
module psg_register_write_tone_select_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [psgw_pkg::CLK_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psgw_pkg::BYTE_W-1:0]   in_write_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psgw_pkg::QUO_W-1:0]    out_tone_freq_hz,
  output logic [psgw_pkg::LVL_W-1:0]    out_tone_level
);

  psgw_pkg::state_t             state_r, state_nxt;
  logic [psgw_pkg::CLK_W-1:0]   clock_hz_r;
  logic                         out_valid_r;
  logic [psgw_pkg::QUO_W-1:0]   freq_r;
  logic [psgw_pkg::LVL_W-1:0]   level_r;

  psgw_pkg::pick_t              pick;
  logic                         in_acc;
  logic                         slot_free;
  logic                         div_start;
  logic                         load_out;
  logic                         div_busy;
  logic                         div_done;
  logic [psgw_pkg::QUO_W-1:0]   quotient;

  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= psgw_pkg::CLOCK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  psgw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_byte (in_write_byte),
    .pick    (pick)
  );

  psgw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clock_hz_r[psgw_pkg::CLK_W-1:5]),
    .divisor  (pick.period),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psgw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psgw_pkg::ST_IDLE: if (in_acc)    state_nxt = psgw_pkg::ST_PICK;
      psgw_pkg::ST_PICK:                state_nxt = psgw_pkg::ST_DIV;
      psgw_pkg::ST_DIV:  if (div_done)  state_nxt = psgw_pkg::ST_DONE;
      psgw_pkg::ST_DONE: if (slot_free) state_nxt = psgw_pkg::ST_IDLE;
      default:                          state_nxt = psgw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      psgw_pkg::ST_IDLE: in_stall  = 1'b0;
      psgw_pkg::ST_PICK: div_start = 1'b1;
      psgw_pkg::ST_DIV:  ;
      psgw_pkg::ST_DONE: load_out  = slot_free;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // silent pick or zero period reports no frequency
  always_ff @(posedge clk) begin
    if (load_out) begin
      freq_r  <= (pick.amp == '0 || pick.period == '0) ? '0 : quotient;
      level_r <= {pick.amp, 2'b00};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tone_freq_hz = freq_r;
  assign out_tone_level   = level_r;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> in_stall)
    else $error("input taken while divider busy");

  a_silent_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tone_level == '0) |-> out_tone_freq_hz == '0)
    else $error("silent result carries a frequency");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> $past(div_done) || $past(state_r == psgw_pkg::ST_DONE))
    else $error("result loaded without finished division");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy && state_r == psgw_pkg::ST_DIV)
    else $error("divider not running after start");
`endif

endmodule

// ----- dv/tb_psg_register_write_tone_select_core.sv -----
`timescale 1ns / 1ps

module tb_psg_register_write_tone_select_core;

  typedef struct packed {
    logic [psgw_pkg::QUO_W-1:0] freq;
    logic [psgw_pkg::LVL_W-1:0] level;
  } tone_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [psgw_pkg::CLK_W-1:0]  cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [psgw_pkg::BYTE_W-1:0] in_write_byte = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [psgw_pkg::QUO_W-1:0]  out_tone_freq_hz;
  logic [psgw_pkg::LVL_W-1:0]  out_tone_level;

  psg_register_write_tone_select_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_write_byte    (in_write_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_freq_hz (out_tone_freq_hz),
    .out_tone_level   (out_tone_level)
  );

  always #5 clk = ~clk;

  // chip register mirror
  logic [psgw_pkg::CLK_W-1:0] chip_hz = psgw_pkg::CLOCK_HZ_RESET;
  logic [1:0]                 lat_ch = 2'd0;
  logic                       lat_vol = 1'b0;
  logic [psgw_pkg::PER_W-1:0] tone_per [psgw_pkg::NUM_TONES];
  logic [psgw_pkg::AMP_W-1:0] tone_amp [psgw_pkg::NUM_TONES];

  logic [psgw_pkg::BYTE_W-1:0] pending_bytes [$];
  tone_result_t      tone_expect_q [$];
  int unsigned       bytes_queued = 0;
  int unsigned       bytes_taken = 0;
  int unsigned       results_seen = 0;
  int unsigned       mismatches = 0;
  logic              byte_accepted = 1'b0;
  logic              quiet = 1'b0;
  int unsigned       in_gap = 0;
  int unsigned       stall_left = 0;
  int unsigned       hold_left = 0;
  logic              hold_done = 1'b0;
  tone_result_t      want;

  initial begin
    for (int i = 0; i < psgw_pkg::NUM_TONES; i++) begin
      tone_per[i] = '0;
      tone_amp[i] = '0;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // apply one port byte to the mirror, return the loudest tone
  function automatic tone_result_t loudest_tone(input logic [psgw_pkg::BYTE_W-1:0] b);
    logic [psgw_pkg::AMP_W-1:0] best_amp;
    logic [psgw_pkg::PER_W-1:0] best_per;
    tone_result_t     r;
    int               i;
    if (b[7]) begin
      lat_ch  = b[6:5];
      lat_vol = b[4];
    end
    if (lat_ch != psgw_pkg::CH_NOISE) begin
      if (lat_vol) tone_amp[lat_ch] = 4'd15 - b[3:0];
      else if (b[7]) tone_per[lat_ch][3:0] = b[3:0];
      else tone_per[lat_ch][9:4] = b[5:0];
    end
    best_amp = '0;
    best_per = '0;
    for (i = 0; i < psgw_pkg::NUM_TONES; i++) begin
      // strict compare: ties keep the lower channel
      if (tone_amp[i] > best_amp) begin
        best_amp = tone_amp[i];
        best_per = tone_per[i];
      end
    end
    r.level = {best_amp, 2'b00};
    if (best_per == '0) r.freq = '0;
    else r.freq = psgw_pkg::QUO_W'((chip_hz / 24'd32) / best_per);
    return r;
  endfunction

  // input side: accept tracking and prediction
  always @(posedge clk) begin
    byte_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      tone_expect_q.push_back(loudest_tone(in_write_byte));
      bytes_taken <= bytes_taken + 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_accepted) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_bytes.size() != 0) begin
        in_valid      <= 1'b1;
        in_write_byte <= pending_bytes.pop_front();
        in_gap        <= quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure; one long hold once traffic is flowing
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (tone_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word freq=%0d level=%0d",
                   out_tone_freq_hz, out_tone_level);
      end else begin
        want = tone_expect_q.pop_front();
        if (out_tone_freq_hz !== want.freq || out_tone_level !== want.level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d exp freq=%0d level=%0d got freq=%0d level=%0d",
                     results_seen, want.freq, want.level,
                     out_tone_freq_hz, out_tone_level);
        end
      end
    end
  end

  task automatic queue_byte(input logic [psgw_pkg::BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_taken != bytes_queued || tone_expect_q.size() != 0);
  endtask

  task automatic set_chip_clock(input logic [psgw_pkg::CLK_W-1:0] hz);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    chip_hz = hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly latch bytes, often with a data byte after, so periods and volumes get real values
  task automatic queue_random_bytes(input int unsigned n);
    int unsigned      k;
    int unsigned      r;
    logic [1:0]       ch;
    logic [3:0]       lo;
    logic [psgw_pkg::BYTE_W-1:0] db;
    k = 0;
    while (k < n) begin
      r  = $urandom_range(0, 9);
      ch = ($urandom_range(0, 7) == 0) ? psgw_pkg::CH_NOISE : 2'($urandom_range(0, 2));
      lo = 4'($urandom_range(0, 15));
      db = 8'($urandom_range(0, 255));
      if (r < 4) begin
        queue_byte({1'b1, ch, 1'b0, lo});
        queue_byte({1'b0, db[6:0]});
        k += 2;
      end else if (r < 7) begin
        queue_byte({1'b1, ch, 1'b1, lo});
        k++;
        if (db[7]) begin
          queue_byte({1'b0, db[6:0]});
          k++;
        end
      end else begin
        queue_byte(db);
        k++;
      end
    end
  endtask

  task automatic run_phase(input logic [psgw_pkg::CLK_W-1:0] hz, input logic calm,
                           input int unsigned n);
    quiet = calm;
    set_chip_clock(hz);
    queue_random_bytes(n);
    wait_idle();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening at the reset clock
    queue_byte(8'h00);  // everything silent
    queue_byte(8'h90);  // ch0 full volume, period still zero
    queue_byte(8'h81);  // ch0 period 1, highest frequency
    queue_byte(8'h3F);  // ch0 period 0x3F1
    queue_byte(8'hFF);  // noise volume latch: no change
    queue_byte(8'h7F);  // data while noise latched
    queue_byte(8'hE0);  // noise tone latch
    queue_byte(8'h55);
    queue_byte(8'hB0);  // ch1 ties ch0, ch0 wins
    queue_byte(8'hAF);
    queue_byte(8'h7F);  // bit 6 of tone data ignored
    queue_byte(8'h9F);  // ch0 silent, ch1 wins
    queue_byte(8'hD3);  // ch2 vol
    queue_byte(8'h7A);  // volume data, upper bits ignored
    queue_byte(8'h00);  // ch2 full, ties ch1
    queue_byte(8'hC0);  // ch2 period low 0
    queue_byte(8'h40);
    queue_byte(8'hBF);  // ch2 wins with period zero
    queue_byte(8'hDF);  // all silent again
    queue_byte(8'h80);
    queue_byte(8'h9A);
    wait_idle();

    run_phase(24'hFFFFFF, 1'b0, 190);
    run_phase(24'd0,      1'b0, 190);
    run_phase(24'd31,     1'b0, 190);
    run_phase(24'd32,     1'b1, 190);
    run_phase(psgw_pkg::CLK_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, 190);
    run_phase(24'd1000000, 1'b1, 190);
    run_phase(psgw_pkg::CLOCK_HZ_RESET, 1'b0, 190);
    run_phase(psgw_pkg::CLK_W'($urandom_range(0, 24'hFFFFFF)), 1'b0, 190);

    repeat (40) @(negedge clk);
    if (mismatches == 0 && tone_expect_q.size() == 0)
      $display("tb_psg_register_write_tone_select_core: done, clean");
    else
      $display("tb_psg_register_write_tone_select_core: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ERROR: timeout");
    $display("tb_psg_register_write_tone_select_core: done, errors");
    $finish;
  end

endmodule
